/* hdl/mesh_face_adjacency_defines.svh */
// Assertion macros shared by the mesh face adjacency modules.
`ifndef MESH_FACE_ADJACENCY_DEFINES_SVH
`define MESH_FACE_ADJACENCY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mesh face adjacency: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mesh face adjacency: next-cycle check failed");

`endif

/* hdl/mfa_pkg.sv */
// Package with constants, codes and controller/datapath interface types.
`default_nettype none
package mfa_pkg;

  localparam int MAX_FACES = 256;
  localparam int IDX_W     = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int CNT_W     = $clog2(MAX_FACES + 1);
  localparam int VERT_W    = 8;
  localparam int WORD_W    = 4 * VERT_W;

  localparam logic [VERT_W-1:0] NO_FACE = 8'hFF;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_store;
    logic load_face;
    logic capture;
    logic read_j;
    logic set_bad;
    logic take_j;
    logic scan_step;
  } mfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad;
    logic scan_last;
  } mfa_stat_t;

endpackage
`default_nettype wire

/* hdl/mfa_ctrl.sv */
// Controller state machine that sequences clears, loads and neighbour queries.
`default_nettype none
`include "mesh_face_adjacency_defines.svh"
module mfa_ctrl
  import mfa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic [1:0] op,
  input  wire mfa_stat_t stat,
  output mfa_cmd_t       cmd,
  output logic           busy,
  output logic           done
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LATCH,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t state;
  logic   take;

  assign busy = (state != ST_IDLE);
  assign take = start && !busy;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (take) begin
          cmd.clear_store = (op == OP_CLEAR);
          cmd.load_face   = (op == OP_LOAD);
          cmd.capture     = (op == OP_QUERY);
        end
      end
      ST_CHECK: begin
        cmd.read_j  = 1'b1;
        cmd.set_bad = stat.bad;
      end
      ST_LATCH: cmd.take_j = 1'b1;
      ST_SCAN:  cmd.scan_step = 1'b1;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (take && op == OP_QUERY) state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (stat.bad) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= ST_LATCH;
          end
        end
        ST_LATCH: state <= ST_SCAN;
        ST_SCAN: begin
          if (stat.scan_last) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MFA_ASSERT_SAME(a_done_idle, clk, rst, done, state == ST_IDLE)
  `MFA_ASSERT_NEXT(a_query_busy, clk, rst, take && op == OP_QUERY, busy && !done)
  `MFA_ASSERT_NEXT(a_bad_skips_scan, clk, rst, state == ST_CHECK && stat.bad,
                   done && state == ST_IDLE)

endmodule
`default_nettype wire

/* hdl/mfa_datapath.sv */
// Datapath with the face store, face count, scan pipeline and neighbour slots.
`default_nettype none
`include "mesh_face_adjacency_defines.svh"
module mfa_datapath
  import mfa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mfa_cmd_t          cmd,
  output mfa_stat_t              stat,
  input  wire logic [VERT_W-1:0] vert_a,
  input  wire logic [VERT_W-1:0] vert_b,
  input  wire logic [VERT_W-1:0] vert_c,
  input  wire logic [VERT_W-1:0] vert_d,
  input  wire logic              is_triangle,
  input  wire logic [VERT_W-1:0] face_index,
  output logic [VERT_W-1:0]      nbr_edge0,
  output logic [VERT_W-1:0]      nbr_edge1,
  output logic [VERT_W-1:0]      nbr_edge2,
  output logic [VERT_W-1:0]      nbr_edge3,
  output logic                   bad_index
);

  // Each entry holds the triangle flag above the four vertex bytes, b0 lowest.
  logic [WORD_W:0]       mem [MAX_FACES];
  logic [WORD_W:0]       rd_data;
  logic [IDX_W-1:0]      rd_addr;
  logic [CNT_W-1:0]      face_count;
  logic                  full;
  logic [VERT_W-1:0]     j_reg;
  logic [WORD_W-1:0]     wj;
  logic                  tri_j;
  logic [IDX_W-1:0]      scan_idx;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_valid;
  logic [3:0]            m;
  logic                  cmp_en;
  logic [VERT_W-1:0]     hit_id;

  assign full    = (face_count == CNT_W'(MAX_FACES));
  assign rd_addr = cmd.read_j ? j_reg[IDX_W-1:0] : scan_idx;

  assign stat.bad       = ({1'b0, j_reg} >= (VERT_W+1)'(face_count));
  assign stat.scan_last = (CNT_W'(scan_idx) == face_count - CNT_W'(1));

  function automatic logic cmd_en_edge(input logic en, input logic x, input logic y);
    return en && x && y;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_face && !full)
      mem[face_count[IDX_W-1:0]] <= {is_triangle, vert_d, vert_c, vert_b, vert_a};
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      face_count <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (cmd.clear_store)
        face_count <= '0;
      else if (cmd.load_face && !full)
        face_count <= face_count + CNT_W'(1);
      rd_valid <= cmd.scan_step;
    end
  end

  // Each byte of face j is looked for among all four bytes of the face just read.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      m[k] = 1'b0;
      for (int n = 0; n < 4; n++)
        if (wj[k*VERT_W +: VERT_W] == rd_data[n*VERT_W +: VERT_W]) m[k] = 1'b1;
    end
  end

  assign hit_id = VERT_W'(rd_idx);
  assign cmp_en = rd_valid && (hit_id != j_reg);

  always_ff @(posedge clk) begin
    if (cmd.take_j) begin
      wj       <= rd_data[WORD_W-1:0];
      tri_j    <= rd_data[WORD_W];
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (cmd.scan_step) rd_idx <= scan_idx;

    if (cmd.capture) begin
      j_reg     <= face_index;
      bad_index <= 1'b0;
      nbr_edge0 <= NO_FACE;
      nbr_edge1 <= NO_FACE;
      nbr_edge2 <= NO_FACE;
      nbr_edge3 <= NO_FACE;
    end else begin
      if (cmd.set_bad) bad_index <= 1'b1;
      if (cmd_en_edge(cmp_en, m[0], m[1])) nbr_edge0 <= hit_id;
      if (cmd_en_edge(cmp_en, m[0], m[2])) nbr_edge1 <= hit_id;
      if (tri_j) begin
        if (cmd_en_edge(cmp_en, m[1], m[2])) nbr_edge2 <= hit_id;
      end else begin
        if (cmd_en_edge(cmp_en, m[1], m[3])) nbr_edge2 <= hit_id;
        if (cmd_en_edge(cmp_en, m[2], m[3])) nbr_edge3 <= hit_id;
      end
    end
  end

  `MFA_ASSERT_SAME(a_scan_in_range, clk, rst, rd_valid, CNT_W'(rd_idx) < face_count)
  `MFA_ASSERT_NEXT(a_full_drops, clk, rst, cmd.load_face && full, $stable(face_count))
  `MFA_ASSERT_NEXT(a_clear_empties, clk, rst, cmd.clear_store, face_count == '0)

endmodule
`default_nettype wire

/* hdl/mesh_face_adjacency.sv */
// Top level of the mesh face adjacency block: controller plus datapath.
`default_nettype none
// Usage: present op and its fields with start high; a request is taken at a
// rising edge where start is high and busy is low. There is no configuration.
// A clear or a load request leaves busy low, so another
// request may follow in the very next cycle. Loads past the store capacity of
// 256 faces are dropped.
// A query raises busy while its index is checked and the face store is swept
// one entry per cycle through its single read port; the result appears with
// done high for one cycle. A query past the loaded count skips the sweep:
// bad_index is set, all slots read 255, and done follows straight after the
// check. done rises in the first cycle that busy is low again.
// The result ports hold their values until the next query is taken, but the
// receiver must take the result in the cycle that done is high; it cannot
// hold results off. Clear and load requests produce no result.
// Reset (rst, synchronous) empties the store and returns the controller to
// idle; the contents of the face memory itself are not cleared.
module mesh_face_adjacency
  import mfa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        op,
  input  wire logic [VERT_W-1:0] vert_a,
  input  wire logic [VERT_W-1:0] vert_b,
  input  wire logic [VERT_W-1:0] vert_c,
  input  wire logic [VERT_W-1:0] vert_d,
  input  wire logic              is_triangle,
  input  wire logic [VERT_W-1:0] face_index,
  output logic                   done,
  output logic [VERT_W-1:0]      nbr_edge0,
  output logic [VERT_W-1:0]      nbr_edge1,
  output logic [VERT_W-1:0]      nbr_edge2,
  output logic [VERT_W-1:0]      nbr_edge3,
  output logic                   bad_index
);

  mfa_cmd_t  cmd;
  mfa_stat_t stat;

  mfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mfa_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .vert_a      (vert_a),
    .vert_b      (vert_b),
    .vert_c      (vert_c),
    .vert_d      (vert_d),
    .is_triangle (is_triangle),
    .face_index  (face_index),
    .nbr_edge0   (nbr_edge0),
    .nbr_edge1   (nbr_edge1),
    .nbr_edge2   (nbr_edge2),
    .nbr_edge3   (nbr_edge3),
    .bad_index   (bad_index)
  );

endmodule
`default_nettype wire
